/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// Needs nothing but a clock and an active-low reset in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising clock edge, quiet while reset is asserted.
`define MCD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define MCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/mcd_pkg.sv */
// Types and codes of the module command decoder.
// Used by the decode logic and the top level; depends on nothing.
`timescale 1ns / 1ps

package mcd_pkg;

    // Command numbers: low three bits of the command byte
    localparam logic [2:0] CMD_RUN    = 3'd0;
    localparam logic [2:0] CMD_ERR1   = 3'd1;
    localparam logic [2:0] CMD_GAIN1  = 3'd2;
    localparam logic [2:0] CMD_GAIN2  = 3'd3;
    localparam logic [2:0] CMD_CUTOFF = 3'd4;
    localparam logic [2:0] CMD_STATUS = 3'd5;
    localparam logic [2:0] CMD_ERR6   = 3'd6;
    localparam logic [2:0] CMD_FORMAT = 3'd7;

    // Argument codes
    localparam logic [7:0] ARG_RUN     = 8'hFF;
    localparam logic [7:0] ARG_STOP    = 8'h00;
    localparam logic [7:0] ARG_STOP_HW = 8'h01;
    localparam logic [7:0] ARG_READ    = 8'h80;
    localparam logic [7:0] ARG_FMT_WR  = 8'h43;
    localparam logic [7:0] ARG_FMT_RD  = 8'h83;

    localparam logic [6:0] MASK_GAIN1  = 7'h03;
    localparam logic [6:0] MASK_GAIN2  = 7'h0F;
    localparam logic [6:0] MASK_CUTOFF = 7'h7F;

    localparam logic [7:0] REPLY_ERR   = 8'hFF;
    localparam logic [7:0] REPLY_FMT24 = 8'h18;
    localparam logic [7:0] REPLY_OK    = 8'h01;
    localparam logic [7:0] REPLY_FAIL  = 8'h00;

    localparam logic [7:0] STATUS_BAD_ARG   = 8'h02;
    localparam logic [7:0] STATUS_READ_DONE = 8'h01;

    typedef enum logic [1:0] {
        RUN_STOPPED    = 2'd0,
        RUN_STOPPED_HW = 2'd1,
        RUN_ACTIVE     = 2'd2
    } run_mode_t;

    typedef struct packed {
        logic [7:0] cmd_byte;
        logic [7:0] arg_byte;
        logic [7:0] fourth_byte;
        logic       set_ok;
    } frame_t;

    typedef struct packed {
        logic       send_reply;
        logic [7:0] reply_b0;
        logic [7:0] reply_b1;
        logic [7:0] reply_b2;
        logic [7:0] reply_b3;
        logic       arm_adc;
        logic       halt_adc;
        logic       stop_pulse;
        logic [6:0] apply_value;
    } reply_t;

    typedef struct packed {
        run_mode_t  run_mode;
        logic [1:0] gain_one;
        logic [3:0] gain_two;
        logic [6:0] cutoff_code;
        logic [7:0] status_code;
        logic       wide_format;
    } settings_t;

endpackage

/* rtl/mcd_frame_if.sv */
// Command frame channel: valid/ready handshake plus the frame fields.
// Standalone; no package needed.
`timescale 1ns / 1ps

interface mcd_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] cmd_byte;
    logic [7:0] arg_byte;
    logic [7:0] fourth_byte;
    logic       set_ok;

    modport source (output valid, cmd_byte, arg_byte, fourth_byte, set_ok, input ready);
    modport sink   (input valid, cmd_byte, arg_byte, fourth_byte, set_ok, output ready);
endinterface

/* rtl/mcd_reply_if.sv */
// Reply channel: valid/ready handshake plus reply bytes and converter pulses.
// Standalone; no package needed.
`timescale 1ns / 1ps

interface mcd_reply_if;
    logic       valid;
    logic       ready;
    logic       send_reply;
    logic [7:0] reply_b0;
    logic [7:0] reply_b1;
    logic [7:0] reply_b2;
    logic [7:0] reply_b3;
    logic       arm_adc;
    logic       halt_adc;
    logic       stop_pulse;
    logic [6:0] apply_value;

    modport source (output valid, send_reply, reply_b0, reply_b1, reply_b2, reply_b3,
                    arm_adc, halt_adc, stop_pulse, apply_value, input ready);
    modport sink   (input valid, send_reply, reply_b0, reply_b1, reply_b2, reply_b3,
                    arm_adc, halt_adc, stop_pulse, apply_value, output ready);
endinterface

/* rtl/mcd_decode.sv */
// Combinational command decode: frame plus current settings give the reply
// and the next settings. Depends on mcd_pkg.
`timescale 1ns / 1ps

module mcd_decode
    import mcd_pkg::*;
(
    input  frame_t    frame,
    input  settings_t cur,
    output settings_t nxt,
    output reply_t    reply
);

    logic [2:0] cmd;
    logic [6:0] mask;
    logic [6:0] masked;
    logic [7:0] target_val;

    assign cmd    = frame.cmd_byte[2:0];
    assign masked = frame.arg_byte[6:0] & mask;

    always_comb
    begin
        unique case (cmd)
            CMD_GAIN1:
            begin
                mask       = MASK_GAIN1;
                target_val = {6'd0, cur.gain_one};
            end
            CMD_GAIN2:
            begin
                mask       = MASK_GAIN2;
                target_val = {4'd0, cur.gain_two};
            end
            default:
            begin
                mask       = MASK_CUTOFF;
                target_val = {1'b0, cur.cutoff_code};
            end
        endcase
    end

    always_comb
    begin
        nxt               = cur;
        reply             = '0;
        reply.reply_b0    = frame.cmd_byte;

        unique case (cmd) inside
            CMD_RUN:
            begin
                if (frame.arg_byte == ARG_RUN)
                begin
                    nxt.run_mode  = RUN_ACTIVE;
                    reply.arm_adc = 1'b1;
                end
                else if (frame.arg_byte == ARG_STOP)
                begin
                    nxt.run_mode   = RUN_STOPPED;
                    reply.halt_adc = 1'b1;
                end
                else if (frame.arg_byte == ARG_STOP_HW)
                begin
                    nxt.run_mode     = RUN_STOPPED_HW;
                    reply.halt_adc   = 1'b1;
                    reply.stop_pulse = 1'b1;
                end
                else
                begin
                    nxt.status_code = STATUS_BAD_ARG;
                end
            end
            CMD_GAIN1, CMD_GAIN2, CMD_CUTOFF:
            begin
                reply.send_reply = 1'b1;
                if (frame.arg_byte == ARG_READ)
                begin
                    reply.reply_b1 = target_val;
                end
                else
                begin
                    reply.apply_value = masked;
                    if (frame.set_ok)
                    begin
                        reply.reply_b1 = REPLY_OK;
                        // store into the register this command addresses
                        if (cmd == CMD_GAIN1)
                            nxt.gain_one = masked[1:0];
                        else if (cmd == CMD_GAIN2)
                            nxt.gain_two = masked[3:0];
                        else
                            nxt.cutoff_code = masked;
                    end
                    else
                    begin
                        reply.reply_b1 = REPLY_FAIL;
                        reply.reply_b3 = REPLY_ERR;
                    end
                end
            end
            CMD_STATUS:
            begin
                reply.send_reply = 1'b1;
                reply.reply_b1   = cur.status_code;
                nxt.status_code  = STATUS_READ_DONE;
            end
            CMD_FORMAT:
            begin
                if (frame.arg_byte == ARG_FMT_WR)
                begin
                    nxt.wide_format  = (frame.fourth_byte != 8'd0);
                    reply.reply_b1   = REPLY_OK;
                    reply.send_reply = 1'b1;
                end
                else if (frame.arg_byte == ARG_FMT_RD)
                begin
                    reply.reply_b1   = REPLY_OK;
                    reply.reply_b3   = cur.wide_format ? REPLY_FMT24 : 8'd0;
                    reply.send_reply = 1'b1;
                end
            end
            default:
            begin
                // unsupported command numbers: error reply
                reply.send_reply = 1'b1;
                reply.reply_b1   = REPLY_FAIL;
                reply.reply_b3   = REPLY_ERR;
            end
        endcase
    end

endmodule

/* rtl/module_command_decoder.sv */
// Top level of the module command decoder: input register, decode, result
// register. Depends on mcd_pkg, mcd_frame_if, mcd_reply_if and mcd_decode.
//
// Usage:
//   frame : sink channel, one beat per four-byte command frame plus set_ok.
//   reply : source channel, exactly one beat per frame, in frame order.
//           send_reply says whether the four reply bytes go on the wire;
//           arm_adc, halt_adc and stop_pulse are one-beat converter pulses.
// Path: a frame beat is registered in the frame register, then decoded into
//   the reply register, from which its reply beat leaves.
// Throughput: one frame per cycle while reply.ready is high, set by the single
//   decode stage that reads and updates the settings registers in the same cycle.
// Stall: when reply.ready is low the reply register holds; one more frame
//   is still taken into the frame register, after which frame.ready drops
//   until the reply beat leaves.
// Reset: rst_n clears both valid flags and the settings (stopped, gains and
//   cutoff 0, status 0, wide_format clear).
`timescale 1ns / 1ps

module module_command_decoder
    import mcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mcd_frame_if.sink  frame,
    mcd_reply_if.source reply
);

    frame_t    frame_reg;
    logic      fvalid_reg;
    reply_t    reply_reg;
    reply_t    reply_next;
    logic      rvalid_reg;
    settings_t set_reg;
    settings_t set_next;
    logic      advance;

    assign advance     = fvalid_reg && (!rvalid_reg || reply.ready);
    assign frame.ready = !fvalid_reg || advance;

    mcd_decode u_decode (
        .frame (frame_reg),
        .cur   (set_reg),
        .nxt   (set_next),
        .reply (reply_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fvalid_reg <= 1'b0;
            rvalid_reg <= 1'b0;
            set_reg    <= '{run_mode: RUN_STOPPED, default: '0};
        end
        else
        begin
            if (frame.ready)
                fvalid_reg <= frame.valid;
            if (advance)
            begin
                rvalid_reg <= 1'b1;
                set_reg    <= set_next;
            end
            else if (reply.ready)
            begin
                rvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers: load on the beat, hold otherwise
    always_ff @(posedge clk)
    begin
        if (frame.ready && frame.valid)
        begin
            frame_reg.cmd_byte    <= frame.cmd_byte;
            frame_reg.arg_byte    <= frame.arg_byte;
            frame_reg.fourth_byte <= frame.fourth_byte;
            frame_reg.set_ok      <= frame.set_ok;
        end
        if (advance)
            reply_reg <= reply_next;
    end

    assign reply.valid       = rvalid_reg;
    assign reply.send_reply  = reply_reg.send_reply;
    assign reply.reply_b0    = reply_reg.reply_b0;
    assign reply.reply_b1    = reply_reg.reply_b1;
    assign reply.reply_b2    = reply_reg.reply_b2;
    assign reply.reply_b3    = reply_reg.reply_b3;
    assign reply.arm_adc     = reply_reg.arm_adc;
    assign reply.halt_adc    = reply_reg.halt_adc;
    assign reply.stop_pulse  = reply_reg.stop_pulse;
    assign reply.apply_value = reply_reg.apply_value;

endmodule

/* rtl/mcd_checker.sv */
// Port-level checks on the reply channel of the module command decoder,
// bound to the top level. Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       valid,
    input logic       ready,
    input logic       send_reply,
    input logic [7:0] reply_b2,
    input logic       arm_adc,
    input logic       halt_adc,
    input logic       stop_pulse,
    input logic [6:0] apply_value
);

    `MCD_ASSERT(a_hold_valid, clk, rst_n, valid && !ready |=> valid, "reply beat dropped while stalled")
    `MCD_ASSERT_ALWAYS(a_b2_zero, clk, valid |-> reply_b2 == 8'd0, "reply byte 2 not zero")
    `MCD_ASSERT(a_arm_alone, clk, rst_n, valid && arm_adc |-> !halt_adc && !send_reply, "arm pulse mixed with halt or reply")
    `MCD_ASSERT(a_stop_halts, clk, rst_n, valid && stop_pulse |-> halt_adc && !send_reply, "stop pulse without halt")
    `MCD_ASSERT(a_apply_reply, clk, rst_n, valid && apply_value != 7'd0 |-> send_reply && !arm_adc, "setting applied without reply")

endmodule

bind module_command_decoder mcd_checker u_mcd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (reply.valid),
    .ready       (reply.ready),
    .send_reply  (reply.send_reply),
    .reply_b2    (reply.reply_b2),
    .arm_adc     (reply.arm_adc),
    .halt_adc    (reply.halt_adc),
    .stop_pulse  (reply.stop_pulse),
    .apply_value (reply.apply_value)
);

/* test/mcd_reply_checker.sv */
// Reply checker for the module command decoder: watches both channels,
// predicts each reply beat from the frame beats and compares field by field.
// Depends on mcd_pkg, mcd_frame_if and mcd_reply_if.
`timescale 1ns / 1ps

module mcd_reply_checker
    import mcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mcd_frame_if        frame,
    mcd_reply_if        reply,
    output int          fail_count,
    output int          outstanding
);

    // Shadow copy of the decoder settings
    run_mode_t  run_mode;
    logic [1:0] gain_one;
    logic [3:0] gain_two;
    logic [6:0] cutoff_code;
    logic [7:0] status_code;
    logic       wide_format;

    reply_t pending_replies[$];

    // Work out the reply to one frame and advance the shadow settings.
    function automatic reply_t decode_frame(frame_t f);
        reply_t     r;
        logic [2:0] cmd;
        logic [6:0] mask;
        logic [6:0] setting;
        r = '0;
        r.reply_b0 = f.cmd_byte;
        cmd = f.cmd_byte[2:0];
        case (cmd)
            CMD_RUN:
            begin
                if (f.arg_byte == ARG_RUN)
                begin
                    run_mode = RUN_ACTIVE;
                    r.arm_adc = 1'b1;
                end
                else if (f.arg_byte == ARG_STOP)
                begin
                    run_mode = RUN_STOPPED;
                    r.halt_adc = 1'b1;
                end
                else if (f.arg_byte == ARG_STOP_HW)
                begin
                    run_mode = RUN_STOPPED_HW;
                    r.halt_adc = 1'b1;
                    r.stop_pulse = 1'b1;
                end
                else
                begin
                    status_code = STATUS_BAD_ARG;
                end
            end
            CMD_GAIN1, CMD_GAIN2, CMD_CUTOFF:
            begin
                r.send_reply = 1'b1;
                mask = (cmd == CMD_GAIN1) ? MASK_GAIN1 :
                       (cmd == CMD_GAIN2) ? MASK_GAIN2 : MASK_CUTOFF;
                if (f.arg_byte == ARG_READ)
                begin
                    r.reply_b1 = (cmd == CMD_GAIN1) ? {6'd0, gain_one} :
                                 (cmd == CMD_GAIN2) ? {4'd0, gain_two} :
                                                      {1'b0, cutoff_code};
                end
                else
                begin
                    setting = f.arg_byte[6:0] & mask;
                    r.apply_value = setting;
                    if (f.set_ok)
                    begin
                        if (cmd == CMD_GAIN1)
                            gain_one = setting[1:0];
                        else if (cmd == CMD_GAIN2)
                            gain_two = setting[3:0];
                        else
                            cutoff_code = setting;
                        r.reply_b1 = REPLY_OK;
                    end
                    else
                    begin
                        r.reply_b1 = REPLY_FAIL;
                        r.reply_b3 = REPLY_ERR;
                    end
                end
            end
            CMD_STATUS:
            begin
                r.reply_b1 = status_code;
                status_code = STATUS_READ_DONE;
                r.send_reply = 1'b1;
            end
            CMD_FORMAT:
            begin
                // unknown subcommand: no change and no reply
                if (f.arg_byte == ARG_FMT_WR)
                begin
                    wide_format = (f.fourth_byte != 8'd0);
                    r.reply_b1 = REPLY_OK;
                    r.send_reply = 1'b1;
                end
                else if (f.arg_byte == ARG_FMT_RD)
                begin
                    r.reply_b1 = REPLY_OK;
                    r.reply_b3 = wide_format ? REPLY_FMT24 : 8'd0;
                    r.send_reply = 1'b1;
                end
            end
            default:
            begin
                r.reply_b1 = REPLY_FAIL;
                r.reply_b3 = REPLY_ERR;
                r.send_reply = 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        frame_t f;
        if (!rst_n)
        begin
            run_mode    = RUN_STOPPED;
            gain_one    = '0;
            gain_two    = '0;
            cutoff_code = '0;
            status_code = '0;
            wide_format = 1'b0;
            pending_replies.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            // Check the reply beat first so a beat never matches a frame of the same edge
            if (reply.valid && reply.ready)
            begin
                if (pending_replies.size() == 0)
                begin
                    $error("reply beat with no frame waiting for it");
                    fail_count++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    check_field("send_reply", want.send_reply, reply.send_reply);
                    check_field("reply_b0", want.reply_b0, reply.reply_b0);
                    check_field("reply_b1", want.reply_b1, reply.reply_b1);
                    check_field("reply_b2", want.reply_b2, reply.reply_b2);
                    check_field("reply_b3", want.reply_b3, reply.reply_b3);
                    check_field("arm_adc", want.arm_adc, reply.arm_adc);
                    check_field("halt_adc", want.halt_adc, reply.halt_adc);
                    check_field("stop_pulse", want.stop_pulse, reply.stop_pulse);
                    check_field("apply_value", want.apply_value, reply.apply_value);
                end
            end
            if (frame.valid && frame.ready)
            begin
                f.cmd_byte    = frame.cmd_byte;
                f.arg_byte    = frame.arg_byte;
                f.fourth_byte = frame.fourth_byte;
                f.set_ok      = frame.set_ok;
                pending_replies.push_back(decode_frame(f));
            end
            outstanding = pending_replies.size();
        end
    end

endmodule

/* test/module_command_decoder_tb.sv */
// Testbench top for the module command decoder: clock, reset, frame and
// reply drivers with random gaps, verdict. Depends on mcd_pkg, both channel
// interfaces, module_command_decoder and mcd_reply_checker.
`timescale 1ns / 1ps

module module_command_decoder_tb;
    import mcd_pkg::*;

    localparam int RANDOM_FRAMES = 1200;
    localparam int MAX_GAP       = 16;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   outstanding;
    bit   frame_burst;
    bit   reply_burst;

    mcd_frame_if frame_ch();
    mcd_reply_if reply_ch();

    module_command_decoder u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .frame (frame_ch),
        .reply (reply_ch)
    );

    mcd_reply_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame       (frame_ch),
        .reply       (reply_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic drive_frame(logic [7:0] cb, logic [7:0] ab, logic [7:0] fb, logic ok);
        int gap;
        if ($urandom_range(0, 39) == 0)
            frame_burst = !frame_burst;
        gap = frame_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        frame_ch.valid       <= 1'b1;
        frame_ch.cmd_byte    <= cb;
        frame_ch.arg_byte    <= ab;
        frame_ch.fourth_byte <= fb;
        frame_ch.set_ok      <= ok;
        @(posedge clk);
        while (!frame_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random frame, mostly with a meaningful argument for its command.
    task automatic drive_random_frame();
        logic [7:0] cb;
        logic [7:0] ab;
        logic [7:0] fb;
        cb = 8'($urandom_range(0, 255));
        ab = 8'($urandom_range(0, 255));
        fb = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) != 0)
        begin
            case (cb[2:0])
                CMD_RUN:
                    case ($urandom_range(0, 3))
                        0: ab = ARG_RUN;
                        1: ab = ARG_STOP;
                        2: ab = ARG_STOP_HW;
                        default: ;
                    endcase
                CMD_GAIN1, CMD_GAIN2, CMD_CUTOFF:
                    if ($urandom_range(0, 2) == 0)
                        ab = ARG_READ;
                CMD_FORMAT:
                    case ($urandom_range(0, 2))
                        0: ab = ARG_FMT_WR;
                        1: ab = ARG_FMT_RD;
                        default: ;
                    endcase
                default: ;
            endcase
        end
        drive_frame(cb, ab, fb, 1'($urandom_range(0, 1)));
    endtask

    // Reply side: stall for a random gap before each beat.
    initial
    begin
        int stall;
        reply_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                reply_burst = !reply_burst;
            stall = reply_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                reply_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            reply_ch.ready <= 1'b1;
            @(posedge clk);
            while (!reply_ch.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        frame_ch.valid       = 1'b0;
        frame_ch.cmd_byte    = 8'd0;
        frame_ch.arg_byte    = 8'd0;
        frame_ch.fourth_byte = 8'd0;
        frame_ch.set_ok      = 1'b0;
        frame_burst          = 1'b0;
        reply_burst          = 1'b0;
        rst_n                = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reads of the reset settings
        drive_frame({5'd0, CMD_GAIN1}, ARG_READ, 8'h00, 1'b1);
        drive_frame({5'h1F, CMD_GAIN2}, ARG_READ, 8'hFF, 1'b0);
        drive_frame({5'd0, CMD_CUTOFF}, ARG_READ, 8'h00, 1'b1);
        drive_frame({5'd0, CMD_STATUS}, 8'h00, 8'h00, 1'b0);
        drive_frame({5'd0, CMD_FORMAT}, ARG_FMT_RD, 8'h00, 1'b0);
        // Run control, then a bad argument and the status it leaves
        drive_frame({5'd0, CMD_RUN}, ARG_RUN, 8'h00, 1'b0);
        drive_frame({5'h10, CMD_RUN}, ARG_STOP, 8'hFF, 1'b1);
        drive_frame({5'd0, CMD_RUN}, ARG_STOP_HW, 8'h00, 1'b0);
        drive_frame({5'd0, CMD_RUN}, 8'h55, 8'h00, 1'b1);
        drive_frame({5'd0, CMD_STATUS}, 8'hFF, 8'h00, 1'b0);
        drive_frame({5'd0, CMD_STATUS}, 8'h00, 8'h00, 1'b0);
        // Settings: applied, refused, read back
        drive_frame({5'd0, CMD_GAIN1}, 8'hFF, 8'h00, 1'b1);
        drive_frame({5'd0, CMD_GAIN1}, ARG_READ, 8'h00, 1'b0);
        drive_frame({5'd0, CMD_GAIN2}, 8'hFF, 8'h00, 1'b0);
        drive_frame({5'd0, CMD_GAIN2}, ARG_READ, 8'h00, 1'b1);
        drive_frame({5'd0, CMD_CUTOFF}, 8'hFF, 8'h00, 1'b1);
        drive_frame({5'd0, CMD_CUTOFF}, ARG_READ, 8'h00, 1'b0);
        drive_frame({5'd0, CMD_CUTOFF}, 8'h00, 8'h00, 1'b1);
        // Format write and read, unknown format subcommand
        drive_frame({5'd0, CMD_FORMAT}, ARG_FMT_WR, 8'hFF, 1'b0);
        drive_frame({5'd0, CMD_FORMAT}, ARG_FMT_RD, 8'h00, 1'b1);
        drive_frame({5'd0, CMD_FORMAT}, ARG_FMT_WR, 8'h00, 1'b0);
        drive_frame({5'd0, CMD_FORMAT}, ARG_FMT_RD, 8'h00, 1'b0);
        drive_frame({5'h1F, CMD_FORMAT}, 8'h00, 8'hFF, 1'b1);
        // Error commands
        drive_frame({5'h1F, CMD_ERR1}, 8'hFF, 8'hFF, 1'b1);
        drive_frame({5'h15, CMD_ERR6}, ARG_READ, 8'h00, 1'b0);

        repeat (RANDOM_FRAMES)
            drive_random_frame();

        frame_ch.valid <= 1'b0;
        @(negedge clk);
        wait (outstanding == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
